[hdl/sha_pkg.sv]
`timescale 1ns / 1ps

package sha_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned BLK_WORDS = 16;
   localparam int unsigned CHAIN_WORDS = 8;
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Command to the message block buffer
   typedef struct packed {
      logic       push;      // pack one message byte
      logic [7:0] byte_val;
      logic       wr;        // write one padding word
      logic       mark;      // padding word closes the partial word with the marker
      logic [3:0] addr;
      logic [1:0] lane;      // bytes already packed in the partial word
      word_type   data;
   } blk_cmd_type;

   // Control from the sequencer to the compression core
   typedef struct packed {
      logic       start;     // compress the buffered block
      logic       clear;     // return chaining words to the initial hash
      logic       rd;        // read one chaining word for the digest
      logic [2:0] addr;
   } core_ctl_type;

   // Status from the compression core
   typedef struct packed {
      logic     done;
      word_type rdata;
   } core_sts_type;

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(word_type e, word_type f, word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type major(word_type a, word_type b, word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic word_type sha_iv(logic [2:0] idx);
      word_type r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic word_type sha_k(logic [5:0] idx);
      word_type r;
      case (idx)
         6'd0:  r = 32'h428a2f98;
         6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;
         6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;
         6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;
         6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;
         6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;
         6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;
         6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;
         6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;
         6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;
         6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;
         6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;
         6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;
         6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;
         6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;
         6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;
         6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;
         6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;
         6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;
         6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;
         6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;
         6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;
         6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;
         6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage

[hdl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// Throughput: one byte per cycle while idle; the 64th byte of a block starts a compression
//   (load, 64 rounds, feed-forward), during which input stalls.
// After the last item: padding words are written, one or two compressions run, then each
//   digest word is read from the core and loaded into the output register.
// Reset: synchronous, active high; clears fill and bit count, chaining words read as IV.

module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] byte_value
   input  logic        req_tuser,    // [0] has_byte
   input  logic        req_tlast,    // last_byte
   // digest channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] digest_word
   output logic [2:0]  rsp_tuser,    // [2:0] word_index
   output logic        rsp_tlast     // last_word
);
   import sha_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;  // take requests, pack bytes
   localparam logic [2:0] ST_BLOCK    = 3'd1;  // compress a full data block
   localparam logic [2:0] ST_PAD      = 3'd2;  // write padding words
   localparam logic [2:0] ST_PAD_HASH = 3'd3;  // compress a padded block
   localparam logic [2:0] ST_OUT_RD   = 3'd4;  // read a digest word
   localparam logic [2:0] ST_OUT_WR   = 3'd5;  // load it into the output register

   logic [2:0]   st_ff, st_in;
   logic [5:0]   fill_ff, fill_in;          // bytes in the current block
   logic [63:0]  count_ff, count_in;        // message length in bits, wraps
   logic         last_pend_ff, last_pend_in;// end of message seen with a full block
   logic [3:0]   wp_ff, wp_in;              // padding word pointer
   logic         tail_ff, tail_in;          // this padded block carries the length
   logic         mark_done_ff, mark_done_in;
   logic [2:0]   oi_ff, oi_in;              // digest word index
   logic         rsp_valid_ff, rsp_valid_in;
   word_type     rsp_data_ff;
   logic [2:0]   rsp_idx_ff;
   logic         rsp_last_ff;

   logic         req_fire;
   logic         rsp_load;
   blk_cmd_type  blk_cmd;
   core_ctl_type core_ctl;
   core_sts_type core_sts;
   logic         bm_ren;
   logic [3:0]   bm_raddr;
   word_type     bm_rdata;

   sha_msgbuf u_msgbuf (
      .clock   (clock),
      .cmd     (blk_cmd),
      .rd_en   (bm_ren),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (core_ctl),
      .sts      (core_sts),
      .bm_ren   (bm_ren),
      .bm_raddr (bm_raddr),
      .bm_rdata (bm_rdata)
   );

   assign req_tready = (st_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      st_in        = st_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      last_pend_in = last_pend_ff;
      wp_in        = wp_ff;
      tail_in      = tail_ff;
      mark_done_in = mark_done_ff;
      oi_in        = oi_ff;
      rsp_load     = 1'b0;

      blk_cmd          = '0;
      blk_cmd.byte_val = req_tdata;
      blk_cmd.lane     = fill_ff[1:0];
      blk_cmd.addr     = (st_ff == ST_PAD) ? wp_ff : fill_ff[5:2];

      core_ctl      = '0;
      core_ctl.addr = oi_ff;

      case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  blk_cmd.push = 1'b1;
                  fill_in      = 6'(fill_ff + 6'd1);
                  count_in     = count_ff + 64'd8;
               end
               if (req_tuser && fill_ff == 6'd63) begin
                  // block full: compress first, pad afterwards if the message ends here
                  core_ctl.start = 1'b1;
                  last_pend_in   = req_tlast;
                  st_in          = ST_BLOCK;
               end else if (req_tlast) begin
                  // length fits behind the marker unless 56 or more bytes are in
                  wp_in        = fill_in[5:2];
                  tail_in      = (fill_in < 6'd56);
                  mark_done_in = 1'b0;
                  st_in        = ST_PAD;
               end
            end
         end
         ST_BLOCK: begin
            if (core_sts.done) begin
               if (last_pend_ff) begin
                  wp_in        = 4'd0;
                  tail_in      = 1'b1;
                  mark_done_in = 1'b0;
                  st_in        = ST_PAD;
               end else begin
                  st_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            // marker word first (once per message), then zeros, the length in the last two words of the tail block
            blk_cmd.wr   = 1'b1;
            blk_cmd.mark = !mark_done_ff;
            if (tail_ff && wp_ff == 4'd14) begin
               blk_cmd.data = count_ff[63:32];
            end else if (tail_ff && wp_ff == 4'd15) begin
               blk_cmd.data = count_ff[31:0];
            end
            mark_done_in = 1'b1;
            wp_in        = 4'(wp_ff + 4'd1);
            if (wp_ff == 4'd15) begin
               core_ctl.start = 1'b1;
               st_in          = ST_PAD_HASH;
            end
         end
         ST_PAD_HASH: begin
            if (core_sts.done) begin
               if (!tail_ff) begin
                  // spill block done; build the one holding the length
                  wp_in   = 4'd0;
                  tail_in = 1'b1;
                  st_in   = ST_PAD;
               end else begin
                  oi_in = 3'd0;
                  st_in = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            // issue the read only when the output register is free by the next edge
            if (!rsp_valid_ff || rsp_tready) begin
               core_ctl.rd = 1'b1;
               st_in       = ST_OUT_WR;
            end
         end
         ST_OUT_WR: begin
            rsp_load = 1'b1;
            if (oi_ff == 3'd7) begin
               // digest fully read: restart the chain for the next message
               core_ctl.clear = 1'b1;
               fill_in        = 6'd0;
               count_in       = 64'd0;
               st_in          = ST_IDLE;
            end else begin
               oi_in = 3'(oi_ff + 3'd1);
               st_in = ST_OUT_RD;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         fill_ff      <= 6'd0;
         count_ff     <= 64'd0;
         last_pend_ff <= 1'b0;
         wp_ff        <= 4'd0;
         tail_ff      <= 1'b0;
         mark_done_ff <= 1'b0;
         oi_ff        <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         last_pend_ff <= last_pend_in;
         wp_ff        <= wp_in;
         tail_ff      <= tail_in;
         mark_done_ff <= mark_done_in;
         oi_ff        <= oi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, held while the consumer stalls
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= core_sts.rdata;
         rsp_idx_ff  <= oi_ff;
         rsp_last_ff <= (oi_ff == 3'd7);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/sha_msgbuf.sv]
`timescale 1ns / 1ps

module sha_msgbuf (
   input  logic                 clock,
   input  sha_pkg::blk_cmd_type cmd,
   input  logic                 rd_en,
   input  logic [3:0]           rd_addr,
   output sha_pkg::word_type    rd_data
);
   import sha_pkg::*;

   word_type    blk_mem [BLK_WORDS];
   logic [23:0] acc_ff, acc_in;
   word_type    rd_data_ff;
   logic        we;
   word_type    wdata;

   always_comb begin
      acc_in = acc_ff;
      we     = 1'b0;
      wdata  = cmd.data;
      if (cmd.push) begin
         // pack big-endian; commit the word on its fourth byte
         acc_in = {acc_ff[15:0], cmd.byte_val};
         if (cmd.lane == 2'd3) begin
            we    = 1'b1;
            wdata = {acc_ff, cmd.byte_val};
         end
      end else if (cmd.wr) begin
         we = 1'b1;
         if (cmd.mark) begin
            case (cmd.lane)
               2'd0: wdata = {PAD_MARK, 24'h000000};
               2'd1: wdata = {acc_ff[7:0], PAD_MARK, 16'h0000};
               2'd2: wdata = {acc_ff[15:0], PAD_MARK, 8'h00};
               default: wdata = {acc_ff[23:0], PAD_MARK};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (we) begin
         blk_mem[cmd.addr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= blk_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sha_core.sv]
`timescale 1ns / 1ps

module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::core_ctl_type ctl,
   output sha_pkg::core_sts_type sts,
   output logic                  bm_ren,
   output logic [3:0]            bm_raddr,
   input  sha_pkg::word_type     bm_rdata
);
   import sha_pkg::*;

   localparam logic [1:0] P_IDLE  = 2'd0;
   localparam logic [1:0] P_LOAD  = 2'd1;
   localparam logic [1:0] P_ROUND = 2'd2;
   localparam logic [1:0] P_ADD   = 2'd3;

   word_type   chain_mem [CHAIN_WORDS];

   logic [1:0] phase_ff, phase_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       fresh_ff, fresh_in;
   logic       rd_iv_ff;
   logic [2:0] rd_idx_ff;
   word_type   cm_q_ff;
   word_type   v_ff [8];
   word_type   v_in [8];
   word_type   wnd_ff [16];
   word_type   wk_ff;

   logic       cm_re;
   logic [2:0] cm_raddr;
   logic       cm_we;
   logic [2:0] cm_waddr;
   word_type   rd_val;
   logic       step_en;
   logic       from_msg;
   logic [5:0] step_j;
   word_type   w_new;
   word_type   t1;
   word_type   t2;

   // chaining word read: reads as the initial hash while fresh
   assign rd_val = rd_iv_ff ? sha_iv(rd_idx_ff) : cm_q_ff;

   always_comb begin
      cm_re    = 1'b0;
      cm_raddr = cnt_ff[2:0];
      if ((phase_ff == P_LOAD || phase_ff == P_ADD) && cnt_ff < 6'd8) begin
         cm_re = 1'b1;
      end else if (phase_ff == P_IDLE && ctl.rd) begin
         cm_re    = 1'b1;
         cm_raddr = ctl.addr;
      end
   end

   // feed-forward writes trail the reads by one entry
   assign cm_we    = (phase_ff == P_ADD) && (cnt_ff != 6'd0);
   assign cm_waddr = 3'(cnt_ff - 6'd1);

   // fetch message words two steps ahead of the round
   assign bm_ren   = (phase_ff == P_LOAD && cnt_ff >= 6'd8) ||
                     (phase_ff == P_ROUND && cnt_ff < 6'd14);
   assign bm_raddr = (phase_ff == P_LOAD) ? {3'b000, cnt_ff[0]} : 4'(cnt_ff + 6'd2);

   // schedule runs one step ahead of the round and pre-adds the constant
   assign step_en  = (phase_ff == P_LOAD && cnt_ff == 6'd9) ||
                     (phase_ff == P_ROUND && cnt_ff != 6'd63);
   assign step_j   = (phase_ff == P_LOAD) ? 6'd0 : 6'(cnt_ff + 6'd1);
   assign from_msg = (phase_ff == P_LOAD) || (cnt_ff < 6'd15);
   assign w_new    = from_msg ? bm_rdata :
                     small_sigma1(wnd_ff[14]) + wnd_ff[9] + small_sigma0(wnd_ff[1]) + wnd_ff[0];

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6]) + wk_ff;
   assign t2 = big_sigma0(v_ff[0]) + major(v_ff[0], v_ff[1], v_ff[2]);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         v_in[k] = v_ff[k];
      end
      if ((phase_ff == P_LOAD || phase_ff == P_ADD) && cnt_ff != 6'd0 && cnt_ff <= 6'd8) begin
         for (int k = 0; k < 7; k++) begin
            v_in[k] = v_ff[k + 1];
         end
         v_in[7] = (phase_ff == P_LOAD) ? rd_val : v_ff[0];
      end else if (phase_ff == P_ROUND) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = 6'(cnt_ff + 6'd1);
      fresh_in = fresh_ff;
      case (phase_ff)
         P_IDLE: begin
            cnt_in = 6'd0;
            if (ctl.start) begin
               phase_in = P_LOAD;
            end
         end
         P_LOAD: begin
            if (cnt_ff == 6'd9) begin
               phase_in = P_ROUND;
               cnt_in   = 6'd0;
            end
         end
         P_ROUND: begin
            if (cnt_ff == 6'd63) begin
               phase_in = P_ADD;
            end
         end
         default: begin
            if (cnt_ff == 6'd8) begin
               phase_in = P_IDLE;
               cnt_in   = 6'd0;
               fresh_in = 1'b0;
            end
         end
      endcase
      if (ctl.clear) begin
         fresh_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= 6'd0;
         fresh_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cm_re) begin
         cm_q_ff   <= chain_mem[cm_raddr];
         rd_iv_ff  <= fresh_ff;
         rd_idx_ff <= cm_raddr;
      end
      if (cm_we) begin
         chain_mem[cm_waddr] <= rd_val + v_ff[0];
      end
      for (int k = 0; k < 8; k++) begin
         v_ff[k] <= v_in[k];
      end
      if (step_en) begin
         for (int k = 0; k < 15; k++) begin
            wnd_ff[k] <= wnd_ff[k + 1];
         end
         wnd_ff[15] <= w_new;
         wk_ff      <= w_new + sha_k(step_j);
      end
   end

   assign sts.done  = (phase_ff == P_ADD) && (cnt_ff == 6'd8);
   assign sts.rdata = rd_val;

endmodule

[hdl/sha_checker.sv]
`timescale 1ns / 1ps

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // hold a stalled digest word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("digest word changed while stalled");

   // no request taken while a digest is still being read out
   a_no_req_mid_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != 3'd7) |-> !req_tready)
      else $error("request taken during digest output");

   // the next digest word needs a memory read, so a gap follows each word but the last
   a_word_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> !rsp_tvalid)
      else $error("digest word without read gap");

   // an end of message always leads to padding work (after a compression if it fills a block)
   a_pad_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("ready right after end of message");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[sim/tb_sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

   // Cycles without any handshake before the run is declared hung. The slowest
   // legal gap is a final request: padding, two compressions, then
   // a digest word that may sit behind a long receiver stall.
   localparam int unsigned QUIET_LIMIT  = 3000;
   // Cycles to keep watching after the last digest word, to catch stray results.
   localparam int unsigned TAIL_CYCLES  = 300;
   // Length of each idling phase, in clock cycles.
   localparam int unsigned PHASE_CYCLES = 500;

   localparam logic [0:7][31:0] START_H = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum int unsigned {
      PH_STEADY,        // no idling on either side
      PH_SENDER_SLOW,   // sender idle most cycles
      PH_SINK_SLOW,     // receiver stalls most cycles
      PH_BOTH_SLOW      // light idling on both sides
   } idle_phase_type;

   // One request as queued for the driver.
   typedef struct {
      logic [7:0] data;
      logic       has;
      logic       fin;
      logic       drain;   // hold this request until every digest word is back
   } byte_req_type;

   // One expected digest word.
   typedef struct {
      logic [31:0] value;
      logic [2:0]  idx;
      logic        fin;
   } digest_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] byte_value
   logic        req_tuser = 1'b0;     // [0] has_byte
   logic        req_tlast = 1'b0;     // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic [2:0]  rsp_tuser;            // [2:0] word_index
   logic        rsp_tlast;            // last_word

   byte_req_type    pending [$];
   digest_word_type digest_due [$];

   // Predicted hasher state.
   logic [31:0]  chain_h [8];
   logic [7:0]   blk [64];
   int unsigned  fill;
   logic [63:0]  msg_bits;

   int unsigned  cycle_no;
   int unsigned  quiet;
   int unsigned  taken;
   int unsigned  words_seen;
   int unsigned  bad_count;
   int unsigned  item_total;
   int unsigned  msg_total;
   int unsigned  noise_total;
   bit           req_took;

   sha256_byte_stream_hasher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Digest predictor
   // ---------------------------------------------------------------------

   function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
      logic [63:0] twice;
      twice = {x, x} >> n;
      return twice[31:0];
   endfunction

   // Return the predictor to the standard initial hash, empty block, zero length.
   function automatic void hash_restart();
      for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
      fill = 0;
      msg_bits = '0;
   endfunction

   // Run the 64 rounds over the buffered block and fold into the chaining words.
   function automatic void fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
      for (int r = 16; r < 64; r++) begin
         s0 = ror32(w[r - 15], 7) ^ ror32(w[r - 15], 18) ^ (w[r - 15] >> 3);
         s1 = ror32(w[r - 2], 17) ^ ror32(w[r - 2], 19) ^ (w[r - 2] >> 10);
         w[r] = s1 + w[r - 7] + s0 + w[r - 16];
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[r] + w[r];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   // Absorb one accepted request; on the end mark, pad, finish and queue the digest.
   function automatic void hash_take(logic [7:0] data, logic has, logic fin);
      int unsigned p;
      if (has) begin
         blk[fill] = data;
         msg_bits += 64'd8;
         fill++;
         if (fill == 64) begin
            fold_block();
            fill = 0;
         end
      end
      if (fin) begin
         p = fill;
         blk[p] = 8'h80;
         p++;
         // No room for the length field: close this block and start another.
         if (p > 56) begin
            while (p < 64) begin
               blk[p] = 8'h00;
               p++;
            end
            fold_block();
            p = 0;
         end
         while (p < 56) begin
            blk[p] = 8'h00;
            p++;
         end
         for (int j = 0; j < 8; j++) blk[63 - j] = msg_bits[8 * j +: 8];
         fold_block();
         for (int j = 0; j < 8; j++)
            digest_due.push_back('{value: chain_h[j], idx: 3'(j), fin: (j == 7)});
         hash_restart();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   function automatic void add_request(logic [7:0] data, logic has, logic fin, logic drain);
      pending.push_back('{data: data, has: has, fin: fin, drain: drain});
      if (has || fin) item_total++;
      else noise_total++;
      if (fin) msg_total++;
   endfunction

   // Queue one message of random bytes, with ignored requests sprinkled in and
   // the end mark either on the last byte or on a request of its own.
   function automatic void add_message(int unsigned len, logic drain);
      logic hold;
      logic sep_end;
      hold = drain;
      sep_end = (len == 0) || ($urandom_range(9) < 3);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            add_request(8'($urandom), 1'b0, 1'b0, hold);
            hold = 1'b0;
         end
         add_request(8'($urandom), 1'b1, (i == len - 1) && !sep_end, hold);
         hold = 1'b0;
      end
      if (sep_end) add_request(8'($urandom), 1'b0, 1'b1, hold);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present requests at the falling edge, hold them until taken
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      byte_req_type   nxt;
      idle_phase_type ph;
      bit             gap;
      bit             stall;
      ph = idle_phase_type'((cycle_no / PHASE_CYCLES) % 4);
      gap = (ph == PH_SENDER_SLOW && $urandom_range(99) < 84)
         || (ph == PH_BOTH_SLOW && $urandom_range(99) < 19);
      stall = (ph == PH_SINK_SLOW && $urandom_range(99) < 84)
         || (ph == PH_BOTH_SLOW && $urandom_range(99) < 19);
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !stall;
         // Advance only when the slot is empty or its request was just taken.
         if (!req_tvalid || req_took) begin
            if (pending.size() != 0 && !gap
                  && !(pending[0].drain && digest_due.size() != 0)) begin
               nxt = pending.pop_front();
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.has;
               req_tlast  <= nxt.fin;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------------

   task automatic report_bad(string why, digest_word_type want);
      bad_count++;
      if (bad_count <= 10)
         $display("[%0t] %s: expected word %08h index %0d last %0b, got %08h index %0d last %0b",
            $realtime, why, want.value, want.idx, want.fin, rsp_tdata, rsp_tuser, rsp_tlast);
   endtask

   always @(posedge clock) begin
      digest_word_type want;
      cycle_no++;
      req_took = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (digest_due.size() == 0) begin
            want = '{value: 'x, idx: 'x, fin: 'x};
            report_bad("unexpected digest word", want);
         end else begin
            want = digest_due.pop_front();
            if (rsp_tdata !== want.value || rsp_tuser !== want.idx || rsp_tlast !== want.fin)
               report_bad("digest word mismatch", want);
         end
      end
      if (req_took) begin
         taken++;
         hash_take(req_tdata, req_tuser, req_tlast);
      end
      if (req_took || (!reset && rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet++;
   end

   // Watchdog: drop the run if both channels sit still too long.
   initial begin
      while (quiet < QUIET_LIMIT) @(posedge clock);
      $display("Timeout after %0d quiet cycles, %0d digest words still due",
         quiet, digest_due.size());
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------

   initial begin
      cycle_no = 0;
      quiet = 0;
      taken = 0;
      words_seen = 0;
      bad_count = 0;
      item_total = 0;
      msg_total = 0;
      noise_total = 0;
      req_took = 1'b0;
      hash_restart();

      // Directed: a request with neither byte nor end mark changes nothing.
      add_request(8'hff, 1'b0, 1'b0, 1'b0);
      // Empty message: end mark with no bytes at all.
      add_request(8'hff, 1'b0, 1'b1, 1'b0);
      // One all-zero byte, end mark on the same request.
      add_request(8'h00, 1'b1, 1'b1, 1'b0);
      // One all-ones byte, end mark on a request of its own.
      add_request(8'hff, 1'b1, 1'b0, 1'b0);
      add_request(8'h00, 1'b0, 1'b1, 1'b0);
      // The classic three-byte message.
      add_request(8'h61, 1'b1, 1'b0, 1'b0);
      add_request(8'h62, 1'b1, 1'b0, 1'b0);
      add_request(8'h63, 1'b1, 1'b1, 1'b0);
      // An ignored request in the middle of a two-byte message.
      add_request(8'ha5, 1'b1, 1'b0, 1'b0);
      add_request(8'h3c, 1'b0, 1'b0, 1'b0);
      add_request(8'h5a, 1'b1, 1'b1, 1'b0);

      // Padding boundaries: length field just fits, needs a second block, and a
      // message that fills a block exactly. Hold the first until the digests drain.
      add_message(55, 1'b1);
      add_message(56, 1'b0);
      add_message(64, 1'b0);

      // Random messages: mostly short, some around one block so the fill crosses
      // the padding limit at random points.
      while (pending.size() < 220) begin
         add_message($urandom_range(3) == 0 ? $urandom_range(70, 50) : $urandom_range(9),
            msg_total == 20);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid || digest_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Hashed %0d messages from %0d requests (%0d ignored), %0d digest words checked",
         msg_total, taken, noise_total, words_seen);
      $display("Lengths covered empty, single byte, padding boundaries and block-sized messages");
      if (bad_count == 0 && digest_due.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d bad digest words, %0d still due", bad_count, digest_due.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sha256_byte_stream_hasher.f]
hdl/sha_pkg.sv
hdl/sha_msgbuf.sv
hdl/sha_core.sv
hdl/sha256_byte_stream_hasher.sv
hdl/sha_checker.sv
sim/tb_sha256_byte_stream_hasher.sv
